### rtl/wcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_pkg
// Types, constants and wheel lookup functions for the candidate generator.
// ----------------------------------------------------------------------------
package wcg_pkg;

    localparam int TABLE_DEPTH  = 8192;
    localparam int ADDR_BITS    = $clog2(TABLE_DEPTH);
    localparam int RESIDUE_BITS = 15;
    localparam int VALUE_BITS   = 64;
    localparam int NPRIMES      = 6;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_CAND = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic OP_START = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE, PH_PRIMES, PH_WHEEL, PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BUILD, ST_DIV, ST_KP, ST_LAST, ST_SEEK_RD, ST_SEEK_EV,
        ST_NEXT, ST_WRD, ST_WEV, ST_ADV, ST_EMIT
    } t_state;

    function automatic logic [3:0] prime_of(input logic [2:0] k);
        logic [3:0] p;
        case (k)
            3'd0: p = 4'd2;
            3'd1: p = 4'd3;
            3'd2: p = 4'd5;
            3'd3: p = 4'd7;
            3'd4: p = 4'd11;
            default: p = 4'd13;
        endcase
        return p;
    endfunction

    // Bit k set when the k-th small prime is part of the wheel.
    function automatic logic [NPRIMES-1:0] wheel_mask(input logic [3:0] mp);
        logic [NPRIMES-1:0] m;
        case (mp) inside
            [4'd0:4'd2]:   m = 6'b000001;
            [4'd3:4'd4]:   m = 6'b000011;
            [4'd5:4'd6]:   m = 6'b000111;
            [4'd7:4'd10]:  m = 6'b001111;
            [4'd11:4'd12]: m = 6'b011111;
            default:       m = 6'b111111;
        endcase
        return m;
    endfunction

    function automatic logic [RESIDUE_BITS-1:0] wheel_mod(input logic [3:0] mp);
        logic [RESIDUE_BITS-1:0] m;
        case (mp) inside
            [4'd0:4'd2]:   m = RESIDUE_BITS'(2);
            [4'd3:4'd4]:   m = RESIDUE_BITS'(6);
            [4'd5:4'd6]:   m = RESIDUE_BITS'(30);
            [4'd7:4'd10]:  m = RESIDUE_BITS'(210);
            [4'd11:4'd12]: m = RESIDUE_BITS'(2310);
            default:       m = RESIDUE_BITS'(30030);
        endcase
        return m;
    endfunction

endpackage

### rtl/wheel_candidate_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_candidate_generator
// Wheel factorization prime candidate generator with an on-chip residue table.
// ----------------------------------------------------------------------------
// A start word (tuser 0) rebuilds the residue table when the wheel modulus has
// changed or no table is built, one odd residue per cycle, then finds begin
// mod modulus with a bit-serial divider and scans the table, one read and
// compare per entry, to the first residue not below begin, before the
// acknowledge word carries the table count. A next word (tuser 1) in the wheel
// phase takes one table read and one 64-bit add and compare, plus a step of
// the base to the next wheel turn when the table wraps. One word is in work
// at a time; the output register lets the next word in while a result waits.
module wheel_candidate_generator
    import wcg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [3:0]   i_cfg_data,    // max_prime
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,     // range_begin[63:0], range_end[127:64]
    input  logic         i_s_tuser,     // op
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,     // value
    output logic [1:0]   o_m_tuser      // kind
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [3:0]                  r_max_prime;
    logic [RESIDUE_BITS-1:0]     mem [0:TABLE_DEPTH-1];
    logic [RESIDUE_BITS-1:0]     r_rd_data;
    logic [ADDR_BITS-1:0]        rd_addr;
    logic [ADDR_BITS-1:0]        r_count, n_count, r_idx, n_idx;
    logic [RESIDUE_BITS-1:0]     r_mod, n_mod, r_r, n_r;
    logic [NPRIMES-1:0]          r_mask, n_mask;
    logic [3:0]                  r_cres [NPRIMES];
    logic [3:0]                  n_cres [NPRIMES];
    logic                        r_ready, n_ready;
    logic [VALUE_BITS-1:0]       r_base, n_base, r_low, n_low, r_high, n_high;
    logic [RESIDUE_BITS:0]       r_rem, n_rem;
    logic [5:0]                  r_bit, n_bit;
    logic [2:0]                  r_ptr, n_ptr;
    logic [1:0]                  r_pkind, n_pkind;
    logic [VALUE_BITS-1:0]       r_pval, n_pval;
    logic                        r_ovalid;
    logic [1:0]                  r_okind;
    logic [VALUE_BITS-1:0]       r_oval;

    logic                        in_acc, emit_go, wr_en;
    logic                        rebuild, coprime, build_end, beyond, kp_ovf, seek_more;
    logic                        prime_hit, wheel_fail, wrap;
    logic [2:0]                  hit_k;
    logic [3:0]                  hit_p;
    logic [RESIDUE_BITS:0]       rem_sh;
    logic [VALUE_BITS:0]         sum_res, sum_mod;
    logic [ADDR_BITS:0]          idx_inc;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign emit_go     = (r_state == ST_EMIT) && (!r_ovalid || i_m_tready);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_oval;
    assign o_m_tuser   = r_okind;

    // Decisions shared by the sequencer and the datapath.
    always_comb begin
        rebuild   = !r_ready || (wheel_mod(r_max_prime) != r_mod);
        coprime   = 1'b1;
        for (int k = 0; k < NPRIMES; k++) begin
            if (r_mask[k] && r_cres[k] == 4'd0) coprime = 1'b0;
        end
        build_end = ({1'b0, r_r} + 16'd2) >= {1'b0, r_mod};
        rem_sh    = {r_rem[RESIDUE_BITS-1:0], r_low[r_bit]};
        beyond    = r_rem > {1'b0, r_rd_data};
        sum_mod   = {1'b0, r_base} + {{(VALUE_BITS-RESIDUE_BITS+1){1'b0}}, r_mod};
        kp_ovf    = sum_mod[VALUE_BITS];
        idx_inc   = {1'b0, r_idx} + 1'b1;
        seek_more = (idx_inc < {1'b0, r_count}) && ({1'b0, r_rd_data} < r_rem);
        prime_hit = 1'b0;
        hit_k     = 3'd0;
        for (int k = NPRIMES - 1; k >= 0; k--) begin
            if (3'(k) >= r_ptr && {60'd0, prime_of(3'(k))} >= r_low) begin
                hit_k = 3'(k);
                prime_hit = 1'b1;
            end
        end
        hit_p     = prime_of(hit_k);
        prime_hit = prime_hit && ({60'd0, hit_p} <= r_high) && r_mask[hit_k];
        sum_res   = {1'b0, r_base} + {{(VALUE_BITS-RESIDUE_BITS+1){1'b0}}, r_rd_data};
        wheel_fail = (r_count == '0) || (r_idx >= r_count) || sum_res[VALUE_BITS]
                     || (sum_res[VALUE_BITS-1:0] > r_high);
        wrap      = idx_inc >= {1'b0, r_count};
        wr_en     = (r_state == ST_BUILD) && coprime;
        case (r_state)
            ST_KP:   rd_addr = r_count - 1'b1;
            default: rd_addr = r_idx;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_tuser != OP_START) n_state = ST_NEXT;
                    else if (rebuild)          n_state = ST_BUILD;
                    else                       n_state = ST_DIV;
                end
            end
            ST_BUILD:   if (build_end) n_state = ST_DIV;
            ST_DIV:     if (r_bit == 6'd0) n_state = ST_KP;
            ST_KP:      n_state = ST_LAST;
            ST_LAST:    n_state = beyond ? ST_EMIT : ST_SEEK_RD;
            ST_SEEK_RD: n_state = ST_SEEK_EV;
            ST_SEEK_EV: n_state = seek_more ? ST_SEEK_RD : ST_EMIT;
            ST_NEXT: begin
                if ((r_phase == PH_PRIMES && !prime_hit) || r_phase == PH_WHEEL)
                    n_state = ST_WRD;
                else
                    n_state = ST_EMIT;
            end
            ST_WRD:     n_state = ST_WEV;
            ST_WEV:     n_state = (!wheel_fail && wrap) ? ST_ADV : ST_EMIT;
            ST_ADV:     n_state = ST_EMIT;
            ST_EMIT:    if (emit_go) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        n_phase = r_phase;  n_count = r_count;  n_idx = r_idx;  n_mod = r_mod;
        n_r = r_r;          n_mask = r_mask;    n_ready = r_ready;
        n_base = r_base;    n_low = r_low;      n_high = r_high;
        n_rem = r_rem;      n_bit = r_bit;      n_ptr = r_ptr;
        n_pkind = r_pkind;  n_pval = r_pval;
        for (int k = 0; k < NPRIMES; k++) n_cres[k] = r_cres[k];
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_s_tuser == OP_START) begin
                    n_low  = i_s_tdata[63:0];
                    n_high = i_s_tdata[127:64];
                    n_rem  = '0;
                    n_bit  = 6'(VALUE_BITS - 1);
                    if (rebuild) begin
                        n_ready = 1'b0;
                        n_mod   = wheel_mod(r_max_prime);
                        n_mask  = wheel_mask(r_max_prime);
                        n_r     = RESIDUE_BITS'(1);
                        n_count = '0;
                        for (int k = 0; k < NPRIMES; k++) n_cres[k] = 4'd1;
                    end
                end
            end
            ST_BUILD: begin
                if (coprime) n_count = r_count + 1'b1;
                n_r = r_r + RESIDUE_BITS'(2);
                // Keep r mod p for every small prime without any division.
                for (int k = 0; k < NPRIMES; k++) begin
                    if (r_cres[k] + 4'd2 >= prime_of(3'(k)))
                        n_cres[k] = r_cres[k] + 4'd2 - prime_of(3'(k));
                    else
                        n_cres[k] = r_cres[k] + 4'd2;
                end
                if (build_end) n_ready = 1'b1;
            end
            ST_DIV: begin
                n_rem = (rem_sh >= {1'b0, r_mod}) ? rem_sh - {1'b0, r_mod} : rem_sh;
                n_bit = r_bit - 1'b1;
            end
            ST_KP: begin
                n_base  = r_low - {{(VALUE_BITS-RESIDUE_BITS-1){1'b0}}, r_rem};
                n_ptr   = 3'd0;
                n_phase = (r_low <= 64'd13) ? PH_PRIMES : PH_WHEEL;
                n_idx   = '0;
                n_pkind = KIND_ACK;
                n_pval  = {{(VALUE_BITS-ADDR_BITS){1'b0}}, r_count};
            end
            ST_LAST: begin
                if (beyond) begin
                    if (kp_ovf) n_phase = PH_DONE;
                    else        n_base  = sum_mod[VALUE_BITS-1:0];
                end
            end
            ST_SEEK_EV: if (seek_more) n_idx = idx_inc[ADDR_BITS-1:0];
            ST_NEXT: begin
                n_pkind = KIND_DONE;
                n_pval  = '0;
                if (r_phase == PH_PRIMES) begin
                    if (prime_hit) begin
                        n_ptr   = hit_k + 1'b1;
                        n_pkind = KIND_CAND;
                        n_pval  = {60'd0, hit_p};
                    end else begin
                        n_phase = PH_WHEEL;
                    end
                end
            end
            ST_WEV: begin
                if (wheel_fail) begin
                    n_phase = PH_DONE;
                    n_pkind = KIND_DONE;
                    n_pval  = '0;
                end else begin
                    n_pkind = KIND_CAND;
                    n_pval  = sum_res[VALUE_BITS-1:0];
                    n_idx   = wrap ? '0 : idx_inc[ADDR_BITS-1:0];
                end
            end
            ST_ADV: begin
                if (kp_ovf) n_phase = PH_DONE;
                else        n_base  = sum_mod[VALUE_BITS-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_count] <= r_r;
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_max_prime <= 4'd13;
            r_count     <= '0;
            r_idx       <= '0;
            r_mod       <= RESIDUE_BITS'(1);
            r_ready     <= 1'b0;
            r_base      <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_ptr       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (i_cfg_valid) r_max_prime <= i_cfg_data;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_mod   <= n_mod;
            r_ready <= n_ready;
            r_base  <= n_base;
            r_low   <= n_low;
            r_high  <= n_high;
            r_ptr   <= n_ptr;
            if (emit_go)         r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask  <= n_mask;
        r_r     <= n_r;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_pkind <= n_pkind;
        r_pval  <= n_pval;
        for (int k = 0; k < NPRIMES; k++) r_cres[k] <= n_cres[k];
        if (emit_go) begin
            r_okind <= r_pkind;
            r_oval  <= r_pval;
        end
    end

    a_build_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BUILD) |-> !r_ready)
        else $error("table marked ready while it is being built");
    a_ready_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready && r_state == ST_IDLE) |-> (r_count != '0))
        else $error("built table is empty");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_phase == PH_WHEEL) |-> (r_idx < r_count))
        else $error("residue index past table count");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PRIMES) |-> (r_ptr <= 3'(NPRIMES)))
        else $error("prime pointer out of range");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the wheel candidate generator. A model of the wheel
// kept in the bench predicts the acknowledge, candidate and exhausted words
// for every accepted request. Directed ranges and random start/next sequences
// run under several wheel sizes and flow-control patterns.
// ----------------------------------------------------------------------------
module testbench
    import wcg_pkg::*;
();

    localparam logic        OP_NEXT = 1'b1;
    localparam logic [63:0] VMAX    = '1;
    localparam int          WHEEL_PRIMES [NPRIMES] = '{2, 3, 5, 7, 11, 13};

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
    } t_word;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [3:0]   i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;
    logic         i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;

    wheel_candidate_generator i_dut (.*);

    // Wheel state as seen by the bench.
    logic [3:0]              wheel_cfg;
    logic [RESIDUE_BITS-1:0] coprime_tbl [TABLE_DEPTH];
    int                      coprime_cnt;
    int                      ring_mod;
    bit                      tbl_built;
    logic [63:0]             turn_base;
    int                      tbl_pos;
    logic [63:0]             span_hi;
    logic [63:0]             span_lo;
    t_phase                  walk_phase;
    int                      prime_idx;

    t_word pending_words [$];
    int    n_err, n_items, n_words, n_cands, n_done_words;
    int    src_idle_pct, sink_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("testbench: done, errors");
        $finish;
    end

    // Rebuild the coprime residue list only when none is built or the wheel modulus changed.
    function automatic void rebuild_wheel();
        int mp, m, r, k;
        bit ok;
        mp = (wheel_cfg < 2) ? 2 : int'(wheel_cfg);
        m = 1;
        for (k = 0; k < NPRIMES; k++)
            if (WHEEL_PRIMES[k] <= mp) m *= WHEEL_PRIMES[k];
        if (tbl_built && m == ring_mod) return;
        coprime_cnt = 0;
        for (r = 1; r < m; r += 2) begin
            ok = 1'b1;
            for (k = 0; k < NPRIMES; k++)
                if (WHEEL_PRIMES[k] <= mp && r % WHEEL_PRIMES[k] == 0) ok = 1'b0;
            if (ok && coprime_cnt < TABLE_DEPTH) begin
                coprime_tbl[coprime_cnt] = RESIDUE_BITS'(r);
                coprime_cnt++;
            end
        end
        ring_mod  = m;
        tbl_built = 1'b1;
    endfunction

    function automatic t_word start_range(logic [63:0] b, logic [63:0] e);
        logic [63:0] kp, last;
        int i;
        i = 0;
        rebuild_wheel();
        span_lo    = b;
        span_hi    = e;
        kp         = b - b % 64'(ring_mod);
        prime_idx  = 0;
        walk_phase = (b <= 64'd13) ? PH_PRIMES : PH_WHEEL;
        last       = 64'(coprime_tbl[coprime_cnt-1]);
        if (b - kp > last) begin
            if (kp > VMAX - 64'(ring_mod)) walk_phase = PH_DONE;
            else kp += 64'(ring_mod);
        end else begin
            while (i + 1 < coprime_cnt && 64'(coprime_tbl[i]) < b - kp) i++;
        end
        turn_base = kp;
        tbl_pos   = i;
        return '{KIND_ACK, 64'(coprime_cnt)};
    endfunction

    function automatic t_word next_candidate();
        logic [63:0] res, x;
        if (walk_phase == PH_PRIMES) begin
            while (prime_idx < NPRIMES && 64'(WHEEL_PRIMES[prime_idx]) < span_lo)
                prime_idx++;
            if (prime_idx < NPRIMES) begin
                x = 64'(WHEEL_PRIMES[prime_idx]);
                if (x <= span_hi && ring_mod % WHEEL_PRIMES[prime_idx] == 0) begin
                    prime_idx++;
                    return '{KIND_CAND, x};
                end
            end
            walk_phase = PH_WHEEL;
        end
        if (walk_phase != PH_WHEEL) return '{KIND_DONE, 64'd0};
        if (coprime_cnt == 0 || tbl_pos >= coprime_cnt) begin
            walk_phase = PH_DONE;
            return '{KIND_DONE, 64'd0};
        end
        res = 64'(coprime_tbl[tbl_pos]);
        x   = turn_base + res;
        if (turn_base > VMAX - res || x > span_hi) begin
            walk_phase = PH_DONE;
            return '{KIND_DONE, 64'd0};
        end
        tbl_pos++;
        if (tbl_pos >= coprime_cnt) begin
            tbl_pos = 0;
            if (turn_base > VMAX - 64'(ring_mod)) walk_phase = PH_DONE;
            else turn_base += 64'(ring_mod);
        end
        return '{KIND_CAND, x};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high so back-to-back words need no gap.
    task automatic send_item(logic op, logic [63:0] b, logic [63:0] e);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {e, b};
        do @(posedge i_clk); while (!o_s_tready);
        if (op == OP_START)
            pending_words.insert(pending_words.size(), start_range(b, e));
        else
            pending_words.insert(pending_words.size(), next_candidate());
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_max_prime(logic [3:0] v);
        wait_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        wheel_cfg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_words++;
            if (o_m_tuser == KIND_CAND) n_cands++;
            if (o_m_tuser == KIND_DONE) n_done_words++;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word kind %0d value %0h",
                         $time, o_m_tuser, o_m_tdata);
                n_err++;
            end else begin
                want = pending_words.pop_front();
                if (o_m_tuser !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d",
                             $time, want.kind, o_m_tuser);
                    n_err++;
                end
                if (o_m_tdata !== want.value) begin
                    $display("%0t: value expected %0h actual %0h",
                             $time, want.value, o_m_tdata);
                    n_err++;
                end
            end
        end
    end

    // Ranges at the low end, where the wheel primes and 1 come out first,
    // plus calls with no open range.
    task automatic test_basic_ranges();
        send_item(OP_NEXT, 64'd0, 64'd0);
        send_item(OP_START, 64'd0, 64'd40);
        repeat (9) send_item(OP_NEXT, VMAX, VMAX);
        write_max_prime(4'd0);
        send_item(OP_START, 64'd3, 64'd9);
        repeat (4) send_item(OP_NEXT, 64'd0, 64'd0);
    endtask

    // Overflow at the top of the value range, begin above end, widest and narrowest wheels.
    task automatic test_edge_cases();
        write_max_prime(4'd15);
        send_item(OP_START, VMAX - 64'd40000, VMAX);
        wait_drained();
        repeat (3) send_item(OP_NEXT, 64'd0, 64'd0);
        send_item(OP_START, 64'd1000, 64'd10);
        repeat (2) send_item(OP_NEXT, 64'd0, 64'd0);
        write_max_prime(4'd1);
        send_item(OP_START, VMAX - 64'd3, VMAX);
        repeat (3) send_item(OP_NEXT, 64'd0, 64'd0);
    endtask

    // Start followed by a burst of next words, with assorted range shapes.
    task automatic test_random_traffic(logic [3:0] mp, int sidle, int sstall, int n);
        int sent, k;
        logic [63:0] b, e;
        write_max_prime(mp);
        src_idle_pct   = sidle;
        sink_stall_pct = sstall;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(3))
                0: b = 64'($urandom_range(60));
                1: b = rand64();
                2: b = VMAX - 64'($urandom_range(70000));
                default: b = 64'($urandom);
            endcase
            case ($urandom_range(3))
                0: e = (b > VMAX - 64'd3000) ? VMAX : b + 64'($urandom_range(3000));
                1: e = rand64();
                2: e = VMAX;
                default: e = b - 64'($urandom_range(50));
            endcase
            send_item(OP_START, b, e);
            k = $urandom_range(1, 40);
            repeat (k) send_item(OP_NEXT, rand64(), rand64());
            sent += k + 1;
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = OP_NEXT;
        i_m_tready     = 1'b0;
        wheel_cfg      = 4'd13;
        coprime_cnt    = 0;
        ring_mod       = 1;
        tbl_built      = 1'b0;
        turn_base      = '0;
        tbl_pos        = 0;
        span_hi        = '0;
        span_lo        = '0;
        walk_phase     = PH_IDLE;
        prime_idx      = 0;
        n_err          = 0;
        n_items        = 0;
        n_words        = 0;
        n_cands        = 0;
        n_done_words   = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_ranges();
        test_edge_cases();
        test_random_traffic(4'd13, 0, 0, 460);
        test_random_traffic(4'd7, 63, 0, 460);
        test_random_traffic(4'd11, 0, 63, 460);
        test_random_traffic(4'd4, 10, 10, 460);

        repeat (20) @(posedge i_clk);
        $display("requests %0d, words checked %0d (%0d candidates, %0d exhausted)",
                 n_items, n_words, n_cands, n_done_words);
        $display("wheels of 2 to 13 under free-running, idle-source and stalled-sink flow");
        if (n_err == 0 && pending_words.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("%0d mismatches, %0d words missing", n_err, pending_words.size());
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
